// File: rtl/core/keyed_table_with_age_timeout_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed report table
// Clocked, reset-qualified property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_TABLE_WITH_AGE_TIMEOUT_CORE_MACROS_SVH
`define KEYED_TABLE_WITH_AGE_TIMEOUT_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define KTAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define KTAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ktat_pkg.sv
// ----------------------------------------------------------------------------
// ktat_pkg
// Field widths, action codes and the request token that walks the cell chain.
// ----------------------------------------------------------------------------
package ktat_pkg;

    localparam int ID_W   = 32;
    localparam int KIND_W = 4;
    localparam int LAT_W  = 31;
    localparam int POS_W  = 32;
    localparam int ELEV_W = 17;
    localparam int TIME_W = 32;

    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_SCAN   = 1'b1;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

    // Request token, handed from cell to cell once per cycle.
    typedef struct packed {
        logic                valid;
        logic                action;
        logic                done;
        logic                inserted;
        logic                refreshed;
        logic                found;
        logic [ID_W-1:0]     id;
        logic [KIND_W-1:0]   kind;
        logic [LAT_W-1:0]    lat;
        logic [POS_W-1:0]    lon;
        logic [ELEV_W-1:0]   elev;
        logic [TIME_W-1:0]   now;
    } t_req;

endpackage

// File: rtl/core/keyed_table_with_age_timeout_core.sv
// ----------------------------------------------------------------------------
// keyed_table_with_age_timeout_core
// Report table keyed by vehicle ID with age-based timeout scan.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        i_action, i_vehicle_id, ...
//   result    out        o_valid (one cycle)  o_inserted ... o_timed_out_id
//   config    in         i_cfg_we             i_cfg_wdata (timeout_ms)
//
// A request walks the chain of TABLE_SLOTS cells, one cell per cycle, and the
// result strobes as it leaves the last cell's register; busy drops the cycle
// after the strobe, so a new request is taken only once the last is through.
// Reset is synchronous, clears the used flags, fill count and last ID, and
// reloads the timeout. The result cannot be stalled.
// ----------------------------------------------------------------------------
module keyed_table_with_age_timeout_core #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [ktat_pkg::ID_W-1:0]       i_vehicle_id,
    input  logic [ktat_pkg::KIND_W-1:0]     i_vehicle_kind,
    input  logic signed [ktat_pkg::LAT_W-1:0]  i_latitude,
    input  logic signed [ktat_pkg::POS_W-1:0]  i_longitude,
    input  logic signed [ktat_pkg::ELEV_W-1:0] i_elevation,
    input  logic [ktat_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_cfg_we,
    input  logic [ktat_pkg::TIME_W-1:0]     i_cfg_wdata,
    output logic                            o_valid,
    output logic                            o_inserted,
    output logic                            o_refreshed,
    output logic                            o_dropped_full,
    output logic                            o_found_timed_out,
    output logic [ktat_pkg::ID_W-1:0]       o_timed_out_id
);
    import ktat_pkg::*;

    localparam int FILL_W = $clog2(TABLE_SLOTS + 1);

    logic [TIME_W-1:0]       r_timeout;
    logic                    r_busy;
    logic [FILL_W-1:0]       r_fill;
    logic [ID_W-1:0]         r_last;
    logic                    w_accept;
    t_req                    w_head;
    t_req                    w_req [0:TABLE_SLOTS];
    t_req                    w_tail;
    logic [TABLE_SLOTS-1:0]  w_used;
    logic                    w_outcome_ok;
    logic                    w_fill_ok;
    logic                    w_room_ok;

    assign w_accept = start && !r_busy;

    always_comb begin
        w_head           = '0;
        w_head.valid     = w_accept;
        w_head.action    = i_action;
        w_head.id        = i_vehicle_id;
        w_head.kind      = i_vehicle_kind;
        w_head.lat       = i_latitude;
        w_head.lon       = i_longitude;
        w_head.elev      = i_elevation;
        w_head.now       = i_now_ms;
    end

    assign w_req[0] = w_head;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        ktat_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_timeout (r_timeout),
            .i_req     (w_req[g]),
            .o_req     (w_req[g+1]),
            .o_used    (w_used[g])
        );
    end

    assign w_tail = w_req[TABLE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fill <= '0;
            r_last <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            if (w_tail.valid && w_tail.inserted) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (w_tail.valid && w_tail.found) begin
                r_last <= w_tail.id;
            end
        end
    end

    assign busy              = r_busy;
    assign o_valid           = w_tail.valid;
    assign o_inserted        = w_tail.inserted;
    assign o_refreshed       = w_tail.refreshed;
    // a report that no cell served ran off the end of a full table
    assign o_dropped_full    = (w_tail.action == ACT_REPORT) && !w_tail.done;
    assign o_found_timed_out = w_tail.found;
    assign o_timed_out_id    = w_tail.found ? w_tail.id : r_last;

    assign w_outcome_ok = $onehot({o_inserted, o_refreshed, o_dropped_full, o_found_timed_out})
                          || (w_tail.action == ACT_SCAN && !o_found_timed_out
                              && !o_inserted && !o_refreshed && !o_dropped_full);
    // used flags run ahead of the fill count while a request is in the chain
    assign w_fill_ok    = ($countones(w_used) == int'(r_fill));
    assign w_room_ok    = (int'(r_fill) < TABLE_SLOTS);

`include "keyed_table_with_age_timeout_core_macros.svh"

    `KTAT_ASSERT(a_strobe_busy, i_clk, i_rst_n, o_valid |-> r_busy, "result outside a request")
    `KTAT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_busy, "busy not raised")
    `KTAT_ASSERT(a_one_outcome, i_clk, i_rst_n, o_valid |-> w_outcome_ok, "conflicting outcome")
    `KTAT_ASSERT(a_fill_used, i_clk, i_rst_n, !r_busy |-> w_fill_ok, "fill count mismatch")
    `KTAT_ASSERT(a_insert_room, i_clk, i_rst_n, (o_valid && o_inserted) |-> w_room_ok, "table full")

endmodule

// File: rtl/core/ktat_cell.sv
// ----------------------------------------------------------------------------
// ktat_cell
// One table slot: holds one entry, serves the request token passing through
// and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module ktat_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ktat_pkg::TIME_W-1:0]     i_timeout,
    input  ktat_pkg::t_req                  i_req,
    output ktat_pkg::t_req                  o_req,
    output logic                            o_used
);
    import ktat_pkg::*;

    logic                r_used;
    logic [ID_W-1:0]     r_id;
    logic [KIND_W-1:0]   r_kind;
    logic [TIME_W-1:0]   r_time;
    logic [POS_W-1:0]    r_lat;
    logic [POS_W-1:0]    r_lon;
    logic [ELEV_W-1:0]   r_elev;
    t_req                r_req;
    t_req                n_req;

    logic                w_live;
    logic                w_hit;
    logic                w_free;
    logic                w_tmo;
    logic [TIME_W-1:0]   w_age;

    assign w_live = i_req.valid && !i_req.done;
    assign w_age  = i_req.now - r_time;
    assign w_hit  = w_live && (i_req.action == ACT_REPORT) && r_used && (r_id == i_req.id);
    // slots fill in order, so the first free cell is the next slot
    assign w_free = w_live && (i_req.action == ACT_REPORT) && !r_used;
    assign w_tmo  = w_live && (i_req.action == ACT_SCAN) && r_used && (w_age > i_timeout);

    always_comb begin
        n_req           = i_req;
        n_req.done      = i_req.done | w_hit | w_free | w_tmo;
        n_req.refreshed = i_req.refreshed | w_hit;
        n_req.inserted  = i_req.inserted | w_free;
        n_req.found     = i_req.found | w_tmo;
        if (w_tmo) begin
            n_req.id = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_free) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_id   <= i_req.id;
            r_kind <= i_req.kind;
        end
        if (w_hit || w_free) begin
            r_time <= i_req.now;
            r_lat  <= {i_req.lat[LAT_W-1], i_req.lat};
            r_lon  <= i_req.lon;
            r_elev <= i_req.elev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req <= n_req;
        end
    end

    assign o_req  = r_req;
    assign o_used = r_used;

endmodule

// File: bench/report_table_monitor.sv
// ----------------------------------------------------------------------------
// report_table_monitor
// Watches the request, result and timeout-register ports of the keyed report
// table. It keeps its own table, computes the outcome of every accepted
// request, and compares each result strobe with the oldest queued outcome.
// ----------------------------------------------------------------------------
module report_table_monitor
    import ktat_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     i_action,
    input  logic [ID_W-1:0]          i_vehicle_id,
    input  logic [KIND_W-1:0]        i_vehicle_kind,
    input  logic signed [LAT_W-1:0]  i_latitude,
    input  logic signed [POS_W-1:0]  i_longitude,
    input  logic signed [ELEV_W-1:0] i_elevation,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic                     i_cfg_we,
    input  logic [TIME_W-1:0]        i_cfg_wdata,
    input  logic                     o_valid,
    input  logic                     o_inserted,
    input  logic                     o_refreshed,
    input  logic                     o_dropped_full,
    input  logic                     o_found_timed_out,
    input  logic [ID_W-1:0]          o_timed_out_id,
    output int                       failures,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            inserted;
        logic            refreshed;
        logic            dropped_full;
        logic            found_timed_out;
        logic [ID_W-1:0] timed_out_id;
    } outcome_t;

    typedef struct {
        logic [ID_W-1:0]     id;
        logic [KIND_W-1:0]   kind;
        logic signed [31:0]  lat;
        logic [POS_W-1:0]    lon;
        logic [ELEV_W-1:0]   elev;
        logic [TIME_W-1:0]   stamp;
    } entry_t;

    entry_t          entries [TABLE_SLOTS];
    bit              used [TABLE_SLOTS];
    int unsigned     fill;
    logic [ID_W-1:0] last_id;
    logic [TIME_W-1:0] timeout_ms;
    outcome_t        outcome_q [$];

    // Apply the request on the input ports to the table and return its outcome.
    function automatic outcome_t update_table();
        outcome_t          o;
        int                hit;
        logic [TIME_W-1:0] age;
        o = '0;
        hit = -1;
        if (i_action == ACT_REPORT) begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (hit < 0 && used[s] && entries[s].id == i_vehicle_id) begin
                    hit = s;
                end
            end
            if (hit >= 0) begin
                o.refreshed = 1'b1;
            end else if (fill < TABLE_SLOTS) begin
                hit = fill;
                fill++;
                used[hit] = 1'b1;
                entries[hit].id = i_vehicle_id;
                entries[hit].kind = i_vehicle_kind;
                o.inserted = 1'b1;
            end else begin
                o.dropped_full = 1'b1;
            end
            if (hit >= 0) begin
                entries[hit].lat = 32'(i_latitude);
                entries[hit].lon = i_longitude;
                entries[hit].elev = i_elevation;
                entries[hit].stamp = i_now_ms;
            end
        end else begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                // age wraps modulo 2^32
                age = i_now_ms - entries[s].stamp;
                if (!o.found_timed_out && used[s] && age > timeout_ms) begin
                    o.found_timed_out = 1'b1;
                    last_id = entries[s].id;
                end
            end
        end
        o.timed_out_id = last_id;
        return o;
    endfunction

    task automatic compare_field(input string what, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        outcome_t want;
        if (!i_rst_n) begin
            timeout_ms = TIMEOUT_RESET;
            fill = 0;
            last_id = '0;
            foreach (used[s]) used[s] = 1'b0;
            outcome_q.delete();
        end else begin
            // retire before queueing so a new request is never matched here
            if (o_valid !== 1'b0) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, actual %b%b%b%b %h",
                             $time, o_inserted, o_refreshed, o_dropped_full,
                             o_found_timed_out, o_timed_out_id);
                    failures++;
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("inserted", want.inserted, o_inserted);
                    compare_field("refreshed", want.refreshed, o_refreshed);
                    compare_field("dropped_full", want.dropped_full, o_dropped_full);
                    compare_field("found_timed_out", want.found_timed_out, o_found_timed_out);
                    compare_field("timed_out_id", want.timed_out_id, o_timed_out_id);
                end
            end
            if (i_cfg_we) begin
                timeout_ms = i_cfg_wdata;
            end
            if (start && !busy) begin
                outcome_q = {outcome_q, update_table()};
            end
        end
        pending = outcome_q.size();
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the keyed report table with directed reports and scans (empty table,
// field extremes, refresh, strict timeout edge, time wrap), then with random
// phases under several timeout settings and sender gap rates. Checking is
// done by report_table_monitor; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench
    import ktat_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = 64;
    localparam int PHASE_ITEMS  = 340;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct {
        logic                     action;
        logic [ID_W-1:0]          id;
        logic [KIND_W-1:0]        kind;
        logic signed [LAT_W-1:0]  lat;
        logic signed [POS_W-1:0]  lon;
        logic signed [ELEV_W-1:0] elev;
        logic [TIME_W-1:0]        now;
    } request_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_action = 1'b0;
    logic [ID_W-1:0]          i_vehicle_id = '0;
    logic [KIND_W-1:0]        i_vehicle_kind = '0;
    logic signed [LAT_W-1:0]  i_latitude = '0;
    logic signed [POS_W-1:0]  i_longitude = '0;
    logic signed [ELEV_W-1:0] i_elevation = '0;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic                     i_cfg_we = 1'b0;
    logic [TIME_W-1:0]        i_cfg_wdata = '0;
    logic                     o_valid;
    logic                     o_inserted;
    logic                     o_refreshed;
    logic                     o_dropped_full;
    logic                     o_found_timed_out;
    logic [ID_W-1:0]          o_timed_out_id;
    int                       failures;
    int                       pending;
    int                       cycle_count = 0;

    keyed_table_with_age_timeout_core #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_vehicle_id(i_vehicle_id),
        .i_vehicle_kind(i_vehicle_kind), .i_latitude(i_latitude),
        .i_longitude(i_longitude), .i_elevation(i_elevation),
        .i_now_ms(i_now_ms), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_inserted(o_inserted), .o_refreshed(o_refreshed),
        .o_dropped_full(o_dropped_full), .o_found_timed_out(o_found_timed_out),
        .o_timed_out_id(o_timed_out_id)
    );

    report_table_monitor #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) monitor (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_vehicle_id(i_vehicle_id),
        .i_vehicle_kind(i_vehicle_kind), .i_latitude(i_latitude),
        .i_longitude(i_longitude), .i_elevation(i_elevation),
        .i_now_ms(i_now_ms), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_inserted(o_inserted), .o_refreshed(o_refreshed),
        .o_dropped_full(o_dropped_full), .o_found_timed_out(o_found_timed_out),
        .o_timed_out_id(o_timed_out_id), .failures(failures), .pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Build a request with a random position inside the legal ranges.
    function automatic request_t fresh_request(input logic action, input logic [ID_W-1:0] id,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [TIME_W-1:0] now);
        request_t r;
        r.action = action;
        r.id = id;
        r.kind = kind;
        r.lat = LAT_W'($urandom_range(32'd1800000000) - 32'd900000000);
        r.lon = POS_W'($urandom_range(32'd3600000000) - 32'd1800000000);
        r.elev = ELEV_W'($urandom_range(32'd65535) - 32'd4096);
        r.now = now;
        return r;
    endfunction

    // Offer the request until accepted; drop start on idle cycles.
    task automatic issue(input request_t r, input int unsigned idle_pct);
        bit accepted;
        accepted = 1'b0;
        while (!accepted) begin
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
            end
            i_action <= r.action;
            i_vehicle_id <= r.id;
            i_vehicle_kind <= r.kind;
            i_latitude <= r.lat;
            i_longitude <= r.lon;
            i_elevation <= r.elev;
            i_now_ms <= r.now;
            @(posedge i_clk);
            accepted = start && !busy;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic send(input logic action, input logic [ID_W-1:0] id,
                        input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now);
        issue(fresh_request(action, id, kind, now), 0);
    endtask

    initial begin
        request_t          r;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] timeout_val;
        logic [ID_W-1:0]   known_ids [$];
        int unsigned       idle_pct;
        int unsigned       draw;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset timeout of 10000 ms
        send(ACT_SCAN, 32'h0, 4'd0, 32'd0);
        r = fresh_request(ACT_REPORT, 32'hA5A5A5A5, 4'd0, 32'd1000);
        r.lat = -LAT_W'(900000000);
        r.lon = -POS_W'(1800000000);
        r.elev = -ELEV_W'(4096);
        issue(r, 0);
        r = fresh_request(ACT_REPORT, 32'hFFFFFFFF, 4'd15, 32'd2000);
        r.lat = LAT_W'(900000000);
        r.lon = POS_W'(1800000000);
        r.elev = ELEV_W'(61439);
        issue(r, 0);
        send(ACT_REPORT, 32'hA5A5A5A5, 4'd7, 32'd3000);
        // age equal to the timeout does not count
        send(ACT_SCAN, 32'h0, 4'd0, 32'd12000);
        send(ACT_SCAN, $urandom, KIND_W'($urandom_range(15)), 32'd12001);
        send(ACT_REPORT, 32'h0, 4'd3, 32'd12001);
        send(ACT_REPORT, 32'hFFFFFFFF, 4'd0, 32'd12001);
        send(ACT_SCAN, 32'h0, 4'd0, 32'd13001);
        send(ACT_REPORT, 32'hA5A5A5A5, 4'd1, 32'd13001);
        send(ACT_SCAN, 32'h0, 4'd0, 32'd13001);
        // stamp everything just below the wrap, then scan across it
        send(ACT_REPORT, 32'hA5A5A5A5, 4'd2, 32'hFFFFFF00);
        send(ACT_REPORT, 32'hFFFFFFFF, 4'd4, 32'hFFFFFF00);
        send(ACT_REPORT, 32'h0, 4'd8, 32'hFFFFFF00);
        send(ACT_REPORT, 32'h5A5A5A5A, 4'd9, 32'hFFFFFF00);
        send(ACT_SCAN, 32'h0, 4'd0, 32'h00002000);
        send(ACT_SCAN, 32'hFFFFFFFF, 4'd15, 32'h00002711);

        known_ids = '{32'hA5A5A5A5, 32'hFFFFFFFF, 32'h0, 32'h5A5A5A5A};
        clock_ms = 32'hFFF00000;

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: timeout_val = $urandom_range(4000, 1000);
                1: timeout_val = '0;
                2: timeout_val = $urandom_range(2000, 200);
                3: timeout_val = '1;
                default: timeout_val = $urandom_range(3000, 1500);
            endcase
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 70 : 0;
            wait_idle();
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= timeout_val;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;

            repeat (PHASE_ITEMS) begin
                clock_ms = clock_ms + $urandom_range(400);
                draw = $urandom_range(99);
                r = fresh_request(ACT_REPORT, $urandom, KIND_W'($urandom_range(15)),
                                  clock_ms);
                // stray time stamp now and then
                if ($urandom_range(19) == 0) r.now = $urandom;
                if (draw < 35) begin
                    r.action = ACT_SCAN;
                end else if (draw < 45) begin
                    known_ids = {known_ids, r.id};
                end else if (draw < 70) begin
                    // favor the low slots so the lowest-index search moves
                    r.id = known_ids[$urandom_range((known_ids.size() < 8) ?
                                                    known_ids.size() - 1 : 7)];
                end else begin
                    r.id = known_ids[$urandom_range(known_ids.size() - 1)];
                end
                issue(r, idle_pct);
            end
        end

        wait_idle();
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
